### rtl/assert_macros.svh
// Assertion macros for the serializer RTL.
// Uses clk and rst_n of the including module; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define VZS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define VZS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define VZS_ASSERT(lbl, prop)
`define VZS_NEVER(lbl, cond)
`endif
`endif

### rtl/vzs_pkg.sv
// Package for the varint/zigzag serializer: mode codes, sequencer types
// and byte constants. No dependencies.
package vzs_pkg;

    typedef enum logic [2:0] {
        MODE_FIX8     = 3'd0,
        MODE_FIX16    = 3'd1,
        MODE_FIX32    = 3'd2,
        MODE_FIX64    = 3'd3,
        MODE_VARINT32 = 3'd4,
        MODE_VARINT64 = 3'd5,
        MODE_ZIGZAG32 = 3'd6,
        MODE_ZIGZAG64 = 3'd7
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        KIND_BE     = 2'd0,
        KIND_LE     = 2'd1,
        KIND_VARINT = 2'd2
    } kind_t;

    localparam logic       ORDER_BIG    = 1'b0;
    localparam logic [6:0] LOW7_MASK    = 7'h7F;
    localparam logic [7:0] CONT_BIT     = 8'h80;
    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

endpackage

### rtl/varint_zigzag_serializer_top.sv
// Varint / zigzag / fixed-width integer serializer, one byte per transfer.
// Depends on vzs_pkg and assert_macros.svh.
//
//  channel   dir  handshake            payload
//  in        in   in_valid / in_stall  mode[2:0], value[63:0]
//  out       out  out_valid/ out_stall out_byte[7:0], last_byte
//  cfg       in   cfg_we               cfg_wdata (byte_order)
//
// An item is loaded, then sent one byte per cycle while out_stall is low:
// 1, 2, 4 or 8 bytes in fixed modes, 1 to 10 bytes in varint modes.
// The single shift register advances by 8 or 7 bits per byte.
// in_stall is high while a value is being serialized; out_stall holds the
// output register and the shifter. Reset clears the sequencer, the output
// valid and byte_order to big endian.
`include "assert_macros.svh"
module varint_zigzag_serializer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import vzs_pkg::*;

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [63:0] sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        order_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_byte_reg, last_byte_next;

    logic        accept;
    logic        advance;
    logic [7:0]  byte_cur;
    logic        last_cur;
    logic [63:0] zz32;
    logic [63:0] zz64;

    assign accept  = (state_reg == ST_IDLE) && in_valid;
    assign advance = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);

    assign zz32 = {32'd0, ({value[30:0], 1'b0} ^ {32{value[31]}})};
    assign zz64 = {value[62:0], 1'b0} ^ {64{value[63]}};

    // Current byte and last flag from the shifter
    always_comb
    begin
        last_cur = (cnt_reg == 4'd1) ||
                   ((kind_reg == KIND_VARINT) && (sh_reg[63:7] == 57'd0));
        unique case (kind_reg)
            KIND_BE: byte_cur = sh_reg[63:56];
            KIND_LE: byte_cur = sh_reg[7:0];
            KIND_VARINT:
                byte_cur = last_cur ? sh_reg[7:0] : (CONT_BIT | {1'b0, sh_reg[6:0] & LOW7_MASK});
            default: byte_cur = sh_reg[7:0];
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (advance && last_cur) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        kind_next      = kind_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_byte_next = last_byte_reg;
        if (accept)
        begin
            kind_next = (order_reg == ORDER_BIG) ? KIND_BE : KIND_LE;
            case (mode)
                MODE_FIX8:
                begin
                    cnt_next = 4'd1;
                    sh_next  = (order_reg == ORDER_BIG) ? {value[7:0], 56'd0} : value;
                end
                MODE_FIX16:
                begin
                    cnt_next = 4'd2;
                    sh_next  = (order_reg == ORDER_BIG) ? {value[15:0], 48'd0} : value;
                end
                MODE_FIX32:
                begin
                    cnt_next = 4'd4;
                    sh_next  = (order_reg == ORDER_BIG) ? {value[31:0], 32'd0} : value;
                end
                MODE_FIX64:
                begin
                    cnt_next = 4'd8;
                    sh_next  = value;
                end
                MODE_VARINT32:
                begin
                    kind_next = KIND_VARINT;
                    cnt_next  = VARINT_MAX_BYTES;
                    sh_next   = {32'd0, value[31:0]};
                end
                MODE_VARINT64:
                begin
                    kind_next = KIND_VARINT;
                    cnt_next  = VARINT_MAX_BYTES;
                    sh_next   = value;
                end
                MODE_ZIGZAG32:
                begin
                    kind_next = KIND_VARINT;
                    cnt_next  = VARINT_MAX_BYTES;
                    sh_next   = zz32;
                end
                default:
                begin
                    kind_next = KIND_VARINT;
                    cnt_next  = VARINT_MAX_BYTES;
                    sh_next   = zz64;
                end
            endcase
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_cur;
            last_byte_next = last_cur;
            cnt_next       = cnt_reg - 4'd1;
            case (kind_reg)
                KIND_BE: sh_next = {sh_reg[55:0], 8'd0};
                KIND_LE: sh_next = {8'd0, sh_reg[63:8]};
                default: sh_next = {7'd0, sh_reg[63:7]};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            order_reg     <= ORDER_BIG;
            kind_reg      <= KIND_BE;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
                order_reg <= cfg_wdata;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        out_byte_reg  <= out_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

    `VZS_ASSERT(a_accept_starts_run, accept |=> (state_reg == ST_RUN))
    `VZS_ASSERT(a_last_ends_run, (advance && last_cur) |=> (state_reg == ST_IDLE))
    `VZS_NEVER(a_cnt_live, (state_reg == ST_RUN) && (cnt_reg == 4'd0))
    `VZS_NEVER(a_fixed_cnt, (state_reg == ST_RUN) && (kind_reg != KIND_VARINT) &&
                            (cnt_reg > 4'd8))

endmodule
